### sv/wrp_pkg.sv
// wrp_pkg: shared constants and types for the wall reflection point unit.
// Depends on nothing; imported by the divider and the top level.
package wrp_pkg;

   localparam int COORD_W          = 16;
   localparam int DIFF_W           = COORD_W + 1;
   localparam int DEN_W            = COORD_W + 2;
   localparam int PROD_W           = 2 * DIFF_W;
   // Every term shares one scale, so the fraction width never enters the arithmetic.
   localparam int COORD_FRAC_BITS  = 8;

   localparam logic [0:0] REG_WALL_POSITION = 1'b0;
   localparam logic [0:0] REG_WALL_PLANE    = 1'b1;

   localparam logic [1:0] PLANE_XZ = 2'd0;
   localparam logic [1:0] PLANE_YZ = 2'd1;
   localparam logic [1:0] PLANE_XY = 2'd2;
   localparam logic [1:0] PLANE_NONE = 2'd3;

   localparam logic signed [COORD_W-1:0] COORD_MAX_C = 16'sh7FFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN_C = -16'sh8000;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Sideband that travels alongside the divider with each request.
   typedef struct packed {
      logic [1:0]  plane;
      logic        zero;
      coord_type   pos;
      coord_type   mic_a;
      coord_type   mic_b;
   } side_type;

endpackage

### sv/wall_reflection_point_unit.sv
// wall_reflection_point_unit: top level, specular reflection point on one axis-aligned wall.
// Depends on wrp_pkg and wrp_div.
// Pipeline: 39 register stages, namely 3 front stages, 35 divider stages (operand register
// plus 34 quotient-bit stages) and the output register. Throughput one request per cycle
// while the output is not stalled. Stalls freeze the whole pipeline;
// a full output register may still take a request if it is drained in the same cycle.
// Reset (synchronous, active high) clears the valid bits and both configuration registers.
module wall_reflection_point_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wrp_pkg::coord_type  req_mic_x,
   input  wrp_pkg::coord_type  req_mic_y,
   input  wrp_pkg::coord_type  req_mic_z,
   input  wrp_pkg::coord_type  req_src_x,
   input  wrp_pkg::coord_type  req_src_y,
   input  wrp_pkg::coord_type  req_src_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wrp_pkg::coord_type  rsp_node_x,
   output wrp_pkg::coord_type  rsp_node_y,
   output wrp_pkg::coord_type  rsp_node_z,
   output logic                rsp_zero_divisor,
   output logic                rsp_saturated,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_data
);
   import wrp_pkg::*;

   // Divider: operand register plus one register per quotient bit.
   localparam int DIV_LAT    = PROD_W;
   localparam int TOT        = 4 + DIV_LAT;

   coord_type  pos_ff;
   logic [1:0] plane_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         plane_ff <= PLANE_XZ;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WALL_POSITION: pos_ff   <= coord_type'(csr_data);
            REG_WALL_PLANE:    plane_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Pipeline moves when the output register is empty or being drained.
   logic advance;
   logic out_valid_ff;
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   logic vld_ff [TOT];

   // Stage 1: select axes, form wall distances and coordinate deltas.
   logic signed [DIFF_W-1:0] dm_ff, da_ff, db_ff;
   logic signed [DEN_W-1:0]  den1_ff;
   side_type                 s1_ff;
   coord_type mn, sn, ma, sa, mb, sb;
   logic signed [DIFF_W-1:0] dm_in, ds_in;

   always_comb begin
      unique case (plane_ff)
         PLANE_XZ: begin mn = req_mic_y; sn = req_src_y; ma = req_mic_x; sa = req_src_x;
                         mb = req_mic_z; sb = req_src_z; end
         PLANE_YZ: begin mn = req_mic_x; sn = req_src_x; ma = req_mic_y; sa = req_src_y;
                         mb = req_mic_z; sb = req_src_z; end
         PLANE_XY: begin mn = req_mic_z; sn = req_src_z; ma = req_mic_x; sa = req_src_x;
                         mb = req_mic_y; sb = req_src_y; end
         default:  begin mn = '0; sn = '0; ma = '0; sa = '0; mb = '0; sb = '0; end
      endcase
      dm_in = DIFF_W'(pos_ff) - DIFF_W'(mn);
      ds_in = DIFF_W'(pos_ff) - DIFF_W'(sn);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dm_ff   <= dm_in;
         da_ff   <= DIFF_W'(sa) - DIFF_W'(ma);
         db_ff   <= DIFF_W'(sb) - DIFF_W'(mb);
         den1_ff <= DEN_W'(dm_in) + DEN_W'(ds_in);
         s1_ff   <= '{plane: plane_ff, zero: 1'b0, pos: pos_ff, mic_a: ma, mic_b: mb};
      end
   end

   // Stage 2: full-width products; flag a zero divisor and feed a safe one.
   logic signed [PROD_W-1:0] pa_ff, pb_ff;
   logic signed [DEN_W-1:0]  den2_ff;
   side_type                 s2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff   <= PROD_W'(dm_ff) * PROD_W'(da_ff);
         pb_ff   <= PROD_W'(dm_ff) * PROD_W'(db_ff);
         den2_ff <= (den1_ff == '0) ? DEN_W'(1) : den1_ff;
         s2_ff   <= '{plane: s1_ff.plane, zero: (den1_ff == '0), pos: s1_ff.pos,
                      mic_a: s1_ff.mic_a, mic_b: s1_ff.mic_b};
      end
   end

   // Stage 3: hold operands in a register before the divider.
   logic signed [PROD_W-1:0] na_ff, nb_ff;
   logic signed [DEN_W-1:0]  den3_ff;
   side_type                 s3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         na_ff   <= s2_ff.zero ? '0 : pa_ff;
         nb_ff   <= s2_ff.zero ? '0 : pb_ff;
         den3_ff <= den2_ff;
         s3_ff   <= s2_ff;
      end
   end

   logic signed [PROD_W-1:0] qa, qb;
   wrp_div #(.NUM_W(PROD_W), .DEN_W(DEN_W)) u_div_a (
      .clock(clock), .advance(advance), .num(na_ff), .den(den3_ff), .quo(qa));
   wrp_div #(.NUM_W(PROD_W), .DEN_W(DEN_W)) u_div_b (
      .clock(clock), .advance(advance), .num(nb_ff), .den(den3_ff), .quo(qb));

   // Delay sideband alongside the divider.
   side_type side_ff [DIV_LAT+1];
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= s3_ff;
         for (int i = 0; i < DIV_LAT; i++) side_ff[i+1] <= side_ff[i];
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOT; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < TOT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Final add, clamp and plane mapping into the output register.
   side_type sf;
   logic signed [PROD_W:0] ra, rb;
   coord_type ca, cb, nx_in, ny_in, nz_in;
   logic sat_in;
   always_comb begin
      sf     = side_ff[DIV_LAT];
      ra     = (PROD_W+1)'(sf.mic_a) + (PROD_W+1)'(qa);
      rb     = (PROD_W+1)'(sf.mic_b) + (PROD_W+1)'(qb);
      sat_in = 1'b0;
      if (ra > (PROD_W+1)'(COORD_MAX_C)) begin ca = COORD_MAX_C; sat_in = 1'b1; end
      else if (ra < (PROD_W+1)'(COORD_MIN_C)) begin ca = COORD_MIN_C; sat_in = 1'b1; end
      else ca = ra[COORD_W-1:0];
      if (rb > (PROD_W+1)'(COORD_MAX_C)) begin cb = COORD_MAX_C; sat_in = 1'b1; end
      else if (rb < (PROD_W+1)'(COORD_MIN_C)) begin cb = COORD_MIN_C; sat_in = 1'b1; end
      else cb = rb[COORD_W-1:0];
      unique case (sf.plane)
         PLANE_XZ: begin nx_in = ca; ny_in = sf.pos; nz_in = cb; end
         PLANE_YZ: begin nx_in = sf.pos; ny_in = ca; nz_in = cb; end
         PLANE_XY: begin nx_in = ca; ny_in = cb; nz_in = sf.pos; end
         default:  begin nx_in = '0; ny_in = '0; nz_in = '0; sat_in = 1'b0; end
      endcase
   end

   coord_type nx_ff, ny_ff, nz_ff;
   logic      zero_ff, sat_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[TOT-1];
      end
      if (advance) begin
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         nz_ff   <= nz_in;
         zero_ff <= sf.zero && (sf.plane != PLANE_NONE);
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_node_x       = nx_ff;
   assign rsp_node_y       = ny_ff;
   assign rsp_node_z       = nz_ff;
   assign rsp_zero_divisor = zero_ff;
   assign rsp_saturated    = sat_ff;

endmodule

### sv/wrp_div.sv
// wrp_div: pipelined signed restoring divider, one quotient bit per stage.
// Depends on wrp_pkg. Quotient truncates toward zero; divisor must be nonzero.
module wrp_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 18
) (
   input  logic                    clock,
   input  logic                    advance,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DEN_W-1:0] den,
   output logic signed [NUM_W-1:0] quo
);
   import wrp_pkg::*;

   localparam int STG = NUM_W;

   logic [NUM_W-1:0] rem_ff [STG+1];
   logic [NUM_W-1:0] q_ff   [STG+1];
   logic [DEN_W-1:0] d_ff   [STG+1];
   logic             neg_ff [STG+1];
   logic [NUM_W-1:0] num_mag;
   logic [DEN_W-1:0] den_mag;

   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         q_ff[0]   <= num_mag;
         d_ff[0]   <= den_mag;
         neg_ff[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      end
   end

   // One quotient bit per stage: shift the next dividend bit in, try subtract.
   for (genvar s = 0; s < STG; s++) begin : g_stage
      logic [NUM_W:0]   trial;
      logic [NUM_W-1:0] rem_in;
      logic [NUM_W-1:0] q_in;
      always_comb begin
         trial  = {rem_ff[s], q_ff[s][NUM_W-1]} - {(NUM_W+1-DEN_W)'(0), d_ff[s]};
         if (trial[NUM_W]) begin
            rem_in = {rem_ff[s][NUM_W-2:0], q_ff[s][NUM_W-1]};
            q_in   = {q_ff[s][NUM_W-2:0], 1'b0};
         end else begin
            rem_in = trial[NUM_W-1:0];
            q_in   = {q_ff[s][NUM_W-2:0], 1'b1};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= rem_in;
            q_ff[s+1]   <= q_in;
            d_ff[s+1]   <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   assign quo = neg_ff[STG] ? NUM_W'(-q_ff[STG]) : NUM_W'(q_ff[STG]);

endmodule
